[src/ffha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and command codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int AW         = 12;            // heap word index bits
  localparam int HEAP_WORDS = 1 << AW;
  localparam int XW         = AW + 3;        // extended address, catches out-of-range
  localparam int SW         = AW + 5;        // block size in bytes
  localparam int CW         = AW + 1;        // sweep / walk counter

  localparam logic [15:0] BLK_MARK  = 16'hfeef;
  localparam int          MIN_USER  = 16;
  localparam int          OVERHEAD  = 32;
  localparam int          MIN_BLOCK = 48;
  localparam int          LINK_NEXT = 3;
  localparam int          LINK_PREV = 4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic          operation;
    logic [15:0]   request_bytes;
    logic [AW-1:0] payload_index;
  } req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] granted_index;
  } rsp_t;

  typedef enum logic [5:0] {
    DP_NOP, DP_CLR, DP_LOAD, DP_RD_P, DP_RD_P3, DP_NEXT, DP_SEL,
    DP_RD_T3, DP_NX, DP_PV, DP_WR_PV3, DP_WR_NX4,
    DP_WR_HEAD_USED, DP_WR_TAIL_NEED, DP_SETUP_REM, DP_WR_P_USED, DP_GRANT,
    DP_WR_T_HEAD, DP_WR_T_TAIL, DP_WR_T3_T, DP_WR_T4_NEW, DP_RD_H4, DP_WR_R3,
    DP_WR_T3_H, DP_WR_T4_R, DP_WR_H4_T,
    DP_RD_Q, DP_CHK, DP_RD_R, DP_ADD, DP_WR_T_ZERO, DP_RD_QM1, DP_SET_LEFT,
    DP_RD_T, DP_WR_Q_ZERO, DP_T_Q,
    DP_FAIL_OOM, DP_FAIL_BAD, DP_OK_FREE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic op_free;
    logic pay_low;
    logic fit;
    logic rem_big;
    logic link_head;
    logic cnt_last;
    logic self_link;
    logic blk_free;
    logic head_bad;
    logic tail_bad;
    logic right_end;
    logic q_zero;
    logic left_ok;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DISP, S_DONE,
    A_RD, A_CHK, A_NEXT, A_SPLIT, A_S1, A_S2, A_USED, A_OK,
    R_0, R_1, R_2, R_3, R_4,
    I_0, I_1, I_E0, I_E1, I_2, I_3, I_4, I_5, I_6, I_7,
    F_HEAD, F_TAIL, F_RIGHT, F_RZ, F_L0, F_L1, F_L2, F_L3, F_L4, F_INS, F_OK
  } state_t;

  // contents of the heap right after reset: one free block over everything
  function automatic logic [63:0] init_word(input logic [AW-1:0] idx);
    logic [63:0] w;
    w = 64'd0;
    if (idx == '0) begin
      w = {BLK_MARK, 48'(HEAP_WORDS * 8)};
    end else if (idx == AW'(HEAP_WORDS - 1)) begin
      w = 64'(HEAP_WORDS * 8);
    end
    return w;
  endfunction

endpackage

[src/ffha_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dpath
// Heap memory, address and pointer registers, size arithmetic and flags.
// ----------------------------------------------------------------------------
module ffha_dpath
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  input  req_t     request,
  output dp_stat_t stat,
  output rsp_t     response
);

  logic [63:0]   mem [HEAP_WORDS];
  logic [63:0]   mem_q;
  logic          oob_q;
  logic [63:0]   rdata;

  logic [XW-1:0] p, q, t, nx, pv;
  logic [AW-1:0] head;
  logic          empty;
  logic [CW-1:0] cnt;
  logic [SW-1:0] sz, need;
  logic          op_free, pay_low;
  logic [1:0]    status;
  logic [AW-1:0] granted;

  logic [XW-1:0] addr;
  logic          we, oob;
  logic [63:0]   wdata;

  logic [SW-1:0] rd_size;
  logic [XW-1:0] rd_link, words_rd, sz_words, need_words, head_x, lw;
  logic          lw_hi;
  logic [SW-1:0] req_raised, req_round, need_calc;

  assign rdata      = oob_q ? 64'd0 : mem_q;
  assign rd_size    = {rdata[SW-1:2], 2'b00};
  assign rd_link    = rdata[XW-1:0];
  assign words_rd   = XW'(rd_size[SW-1:3]);
  assign sz_words   = XW'(sz[SW-1:3]);
  assign need_words = XW'(need[SW-1:3]);
  assign head_x     = XW'(head);
  assign lw         = rdata[XW+2:3];
  assign lw_hi      = |rdata[63:XW+3];

  // request raised to the minimum, rounded to 8, plus block overhead
  always_comb begin
    req_raised = (request.request_bytes < 16'(MIN_USER)) ? SW'(MIN_USER)
                                                         : SW'(request.request_bytes);
    req_round  = (req_raised + SW'(7)) & ~SW'(7);
    need_calc  = req_round + SW'(OVERHEAD);
  end

  always_comb begin
    addr  = p;
    we    = 1'b0;
    wdata = 64'd0;
    case (cmd.op)
      DP_CLR: begin
        addr  = XW'(cnt[AW-1:0]);
        we    = 1'b1;
        wdata = init_word(cnt[AW-1:0]);
      end
      DP_RD_P:   addr = p;
      DP_RD_P3:  addr = p + XW'(LINK_NEXT);
      DP_RD_T3:  addr = t + XW'(LINK_NEXT);
      DP_NX:     addr = t + XW'(LINK_PREV);
      DP_WR_PV3: begin
        addr = pv + XW'(LINK_NEXT); we = 1'b1; wdata = 64'(nx);
      end
      DP_WR_NX4: begin
        addr = nx + XW'(LINK_PREV); we = 1'b1; wdata = 64'(pv);
      end
      DP_WR_HEAD_USED: begin
        addr = p; we = 1'b1; wdata = {BLK_MARK, 48'(need)} | 64'd1;
      end
      DP_WR_TAIL_NEED: begin
        addr = p + need_words - XW'(1); we = 1'b1; wdata = 64'(need);
      end
      DP_WR_P_USED: begin
        addr = p; we = 1'b1; wdata = rdata | 64'd1;
      end
      DP_WR_T_HEAD: begin
        addr = t; we = 1'b1; wdata = {BLK_MARK, 48'(sz)};
      end
      DP_WR_T_TAIL: begin
        addr = t + sz_words - XW'(1); we = 1'b1; wdata = 64'(sz);
      end
      DP_WR_T3_T: begin
        addr = t + XW'(LINK_NEXT); we = 1'b1; wdata = 64'(t);
      end
      DP_WR_T4_NEW: begin
        addr = t + XW'(LINK_PREV); we = 1'b1; wdata = 64'(t);
      end
      DP_RD_H4:  addr = head_x + XW'(LINK_PREV);
      DP_WR_R3: begin
        addr = rd_link + XW'(LINK_NEXT); we = 1'b1; wdata = 64'(t);
      end
      DP_WR_T3_H: begin
        addr = t + XW'(LINK_NEXT); we = 1'b1; wdata = 64'(head);
      end
      DP_WR_T4_R: begin
        addr = t + XW'(LINK_PREV); we = 1'b1; wdata = rdata;
      end
      DP_WR_H4_T: begin
        addr = head_x + XW'(LINK_PREV); we = 1'b1; wdata = 64'(t);
      end
      DP_RD_Q:   addr = q;
      DP_CHK:    addr = q + words_rd - XW'(1);
      DP_RD_R:   addr = q + sz_words;
      DP_WR_T_ZERO: begin
        addr = t; we = 1'b1;
      end
      DP_RD_QM1: addr = q - XW'(1);
      DP_RD_T:   addr = t;
      DP_WR_Q_ZERO: begin
        addr = q; we = 1'b1;
      end
      default:   addr = p;
    endcase
  end

  assign oob = addr[XW-1:AW] != '0;

  // single port heap memory, read data registered
  always_ff @(posedge clk) begin
    if (we && !oob) begin
      mem[addr[AW-1:0]] <= wdata;
    end
    mem_q <= mem[addr[AW-1:0]];
    oob_q <= oob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      empty <= 1'b0;
      cnt   <= '0;
    end else begin
      case (cmd.op)
        DP_CLR:  cnt <= cnt + CW'(1);
        DP_LOAD: begin
          op_free <= request.operation;
          need    <= need_calc;
          p       <= head_x;
          cnt     <= '0;
          q       <= XW'(request.payload_index) - XW'(3);
          pay_low <= request.payload_index < AW'(3);
        end
        DP_NEXT: begin
          p   <= rd_link;
          cnt <= cnt + CW'(1);
        end
        DP_SEL: begin
          sz <= rd_size;
          t  <= p;
        end
        DP_NX: nx <= rd_link;
        DP_PV: begin
          pv <= rd_link;
          if (nx == t) begin
            empty <= 1'b1;
          end
        end
        DP_WR_NX4: begin
          if (t == head_x) begin
            head <= nx[AW-1:0];
          end
        end
        DP_SETUP_REM: begin
          sz <= sz - need;
          t  <= p + need_words;
        end
        DP_WR_T4_NEW: begin
          head  <= t[AW-1:0];
          empty <= 1'b0;
        end
        DP_GRANT: begin
          status  <= ST_OK;
          granted <= AW'(p + XW'(3));
        end
        DP_FAIL_OOM: begin
          status  <= ST_OOM;
          granted <= '0;
        end
        DP_FAIL_BAD: begin
          status  <= ST_BAD;
          granted <= '0;
        end
        DP_OK_FREE: begin
          status  <= ST_OK;
          granted <= '0;
        end
        DP_CHK:       sz <= rd_size;
        DP_RD_R:      t  <= q + sz_words;
        DP_ADD:       sz <= sz + rd_size;
        DP_SET_LEFT:  t  <= q - lw;
        DP_WR_Q_ZERO: q  <= t;
        DP_T_Q:       t  <= q;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.empty     = empty;
    stat.op_free   = op_free;
    stat.pay_low   = pay_low;
    stat.fit       = rd_size >= need;
    stat.rem_big   = (sz - need) >= SW'(MIN_BLOCK);
    stat.link_head = rd_link == head_x;
    stat.cnt_last  = cnt == CW'(HEAP_WORDS - 1);
    stat.self_link = nx == t;
    stat.blk_free  = (rdata[63:48] == BLK_MARK) && !rdata[0];
    stat.head_bad  = (rdata[63:48] != BLK_MARK) || !rdata[0]
                     || (rd_size < SW'(MIN_BLOCK)) || rd_size[2]
                     || ((q + words_rd) > XW'(HEAP_WORDS));
    stat.tail_bad  = rdata != 64'(sz);
    stat.right_end = (q + sz_words) == XW'(HEAP_WORDS);
    stat.q_zero    = q == '0;
    stat.left_ok   = !lw_hi && (lw != '0) && (lw <= q);
  end

  assign response.status        = status;
  assign response.granted_index = granted;

endmodule

[src/ffha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate, free and the shared list unlink / link routines.
// ----------------------------------------------------------------------------
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = DP_NOP;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_CLR: begin
        cmd.op = DP_CLR;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op_free) begin
          if (stat.pay_low) begin
            cmd.op = DP_FAIL_BAD; state_next = S_DONE;
          end else begin
            cmd.op = DP_RD_Q; state_next = F_HEAD;
          end
        end else if (stat.empty) begin
          cmd.op = DP_FAIL_OOM; state_next = S_DONE;
        end else begin
          cmd.op = DP_RD_P; state_next = A_CHK;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      // first-fit walk
      A_RD: begin
        cmd.op = DP_RD_P; state_next = A_CHK;
      end
      A_CHK: begin
        if (stat.fit) begin
          cmd.op = DP_SEL; ret_next = A_SPLIT; state_next = R_0;
        end else begin
          cmd.op = DP_RD_P3; state_next = A_NEXT;
        end
      end
      A_NEXT: begin
        if (stat.link_head || stat.cnt_last) begin
          cmd.op = DP_FAIL_OOM; state_next = S_DONE;
        end else begin
          cmd.op = DP_NEXT; state_next = A_RD;
        end
      end
      A_SPLIT: begin
        if (stat.rem_big) begin
          cmd.op = DP_WR_HEAD_USED; state_next = A_S1;
        end else begin
          cmd.op = DP_RD_P; state_next = A_USED;
        end
      end
      A_S1: begin
        cmd.op = DP_WR_TAIL_NEED; state_next = A_S2;
      end
      A_S2: begin
        cmd.op = DP_SETUP_REM; ret_next = A_OK; state_next = I_0;
      end
      A_USED: begin
        cmd.op = DP_WR_P_USED; state_next = A_OK;
      end
      A_OK: begin
        cmd.op = DP_GRANT; state_next = S_DONE;
      end
      // unlink block t
      R_0: begin
        cmd.op = DP_RD_T3; state_next = R_1;
      end
      R_1: begin
        cmd.op = DP_NX; state_next = R_2;
      end
      R_2: begin
        cmd.op     = DP_PV;
        state_next = stat.self_link ? ret : R_3;
      end
      R_3: begin
        cmd.op = DP_WR_PV3; state_next = R_4;
      end
      R_4: begin
        cmd.op = DP_WR_NX4; state_next = ret;
      end
      // link block t of size sz just before the head
      I_0: begin
        cmd.op = DP_WR_T_HEAD; state_next = I_1;
      end
      I_1: begin
        cmd.op     = DP_WR_T_TAIL;
        state_next = stat.empty ? I_E0 : I_2;
      end
      I_E0: begin
        cmd.op = DP_WR_T3_T; state_next = I_E1;
      end
      I_E1: begin
        cmd.op = DP_WR_T4_NEW; state_next = ret;
      end
      I_2: begin
        cmd.op = DP_RD_H4; state_next = I_3;
      end
      I_3: begin
        cmd.op = DP_WR_R3; state_next = I_4;
      end
      I_4: begin
        cmd.op = DP_WR_T3_H; state_next = I_5;
      end
      I_5: begin
        cmd.op = DP_RD_H4; state_next = I_6;
      end
      I_6: begin
        cmd.op = DP_WR_T4_R; state_next = I_7;
      end
      I_7: begin
        cmd.op = DP_WR_H4_T; state_next = ret;
      end
      // free: checks, then right and left merge
      F_HEAD: begin
        if (stat.head_bad) begin
          cmd.op = DP_FAIL_BAD; state_next = S_DONE;
        end else begin
          cmd.op = DP_CHK; state_next = F_TAIL;
        end
      end
      F_TAIL: begin
        if (stat.tail_bad) begin
          cmd.op = DP_FAIL_BAD; state_next = S_DONE;
        end else if (stat.right_end) begin
          state_next = F_L0;
        end else begin
          cmd.op = DP_RD_R; state_next = F_RIGHT;
        end
      end
      F_RIGHT: begin
        if (stat.blk_free) begin
          cmd.op = DP_ADD; ret_next = F_RZ; state_next = R_0;
        end else begin
          state_next = F_L0;
        end
      end
      F_RZ: begin
        cmd.op = DP_WR_T_ZERO; state_next = F_L0;
      end
      F_L0: begin
        if (stat.q_zero) begin
          state_next = F_INS;
        end else begin
          cmd.op = DP_RD_QM1; state_next = F_L1;
        end
      end
      F_L1: begin
        if (stat.left_ok) begin
          cmd.op = DP_SET_LEFT; state_next = F_L2;
        end else begin
          state_next = F_INS;
        end
      end
      F_L2: begin
        cmd.op = DP_RD_T; state_next = F_L3;
      end
      F_L3: begin
        if (stat.blk_free) begin
          cmd.op = DP_ADD; ret_next = F_L4; state_next = R_0;
        end else begin
          state_next = F_INS;
        end
      end
      F_L4: begin
        cmd.op = DP_WR_Q_ZERO; state_next = F_INS;
      end
      F_INS: begin
        cmd.op = DP_T_Q; ret_next = F_OK; state_next = I_0;
      end
      F_OK: begin
        cmd.op = DP_OK_FREE; state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a heap of 64-bit words with boundary tags.
// ----------------------------------------------------------------------------
// usage:
//   a word on request is taken at the clock edge where start is high and
//   busy is low; operation 0 allocates request_bytes, 1 frees payload_index.
//   each word gives exactly one response word, shown for one cycle with done
//   high; the receiver has to take it then, there is no back pressure.
// operation (single memory port, one access per cycle):
//   allocate walks the free list node by node, then unlinks the fitting
//   node, splits it when the rest is large enough and relinks the rest;
//   an empty list gives out of memory without a walk.
//   free checks both tags, merges with free neighbours on either side and
//   links the result; a rejected free returns before any merge.
//   busy stays high from the accepted word to the done cycle; one word is
//   processed at a time, the next can be taken in the cycle after done.
// reset:
//   after rst the heap memory is rebuilt as one free block, one word per
//   cycle, and busy stays high until every word is written.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t response
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ffha_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .stat     (stat),
    .response (response)
  );

endmodule

[src/ffha_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_check
// Port-level checks of the allocator's command handshake and responses.
// ----------------------------------------------------------------------------
module ffha_check
  import ffha_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t request,
  input logic done,
  input rsp_t response
);

  // an accepted word keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("response strobe while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("response strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.status == ST_OK || response.status == ST_OOM
              || response.status == ST_BAD))
    else $error("undefined status code");

  // failed requests never hand out an index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response.status != ST_OK) |-> response.granted_index == '0)
    else $error("nonzero index on failure");

endmodule

bind first_fit_heap_allocator ffha_check u_check (.*);
